// ===== src/gle_pkg.sv =====
`timescale 1ns / 1ps

package gle_pkg;

    // Fixed-point scaling of the ports and of the internal words
    localparam int ANGLE_FRAC_BITS  = 32;
    localparam int LENGTH_FRAC_BITS = 16;
    localparam int CORDIC_STEPS_DEF = 40;
    localparam int QF               = 60;
    localparam int ROT_FRAC         = 30;
    localparam int INV_ITERS        = 8;

    // Port and storage widths
    localparam int LON_W     = 41;
    localparam int LAT_W     = 40;
    localparam int HGT_W     = 34;
    localparam int OUT_W     = 43;
    localparam int SEMI_W    = 33;
    localparam int ECC_W     = 45;
    localparam int CFG_W     = 45;
    localparam int CFG_IDX_W = 2;
    localparam int RED_W     = 43;
    localparam int ROT_W     = 32;
    localparam int ORG_W     = 48;
    localparam int ECC_SHIFT = QF - 48;
    localparam int NUM_W     = SEMI_W + LENGTH_FRAC_BITS;
    localparam int MM_PER_M  = 1000;

    // Reciprocal divide by 1000: 51-bit constant, numerator in 4 chunks of 13 bits
    localparam int RECIP_W    = 51;
    localparam int DIV_CHUNK  = 13;
    localparam int DIV_CHUNKS = 4;

    typedef logic [63:0] word_t;

    localparam word_t QONE    = 64'd1 << QF;
    localparam word_t SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_LIMIT = 64'sd1 <<< 41;

    // Angle range reduction constants (degrees scaled by 2^ANGLE_FRAC_BITS)
    localparam logic signed [RED_W-1:0] TURN    = RED_W'(64'd360 << ANGLE_FRAC_BITS);
    localparam logic signed [RED_W-1:0] HALF    = RED_W'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic signed [RED_W-1:0] QUARTER = RED_W'(64'd90 << ANGLE_FRAC_BITS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECC  = 2'd2;

    typedef enum logic [1:0] {
        SH_Q60,
        SH_Q61,
        SH_ANG,
        SH_Q30
    } mul_shift_t;

    typedef struct packed {
        logic       start;
        mul_shift_t sh;
        word_t      a;
        word_t      b;
    } mul_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_ZMUL,
        S_CORDIC,
        S_MUL,
        S_DIFF,
        S_DONE
    } seq_state_t;

    typedef enum logic [3:0] {
        OP_SPSP,
        OP_E2W,
        OP_YY,
        OP_WT,
        OP_Y,
        OP_N,
        OP_PC,
        OP_P0,
        OP_P1,
        OP_NE,
        OP_P2,
        OP_M3,
        OP_M4,
        OP_M6,
        OP_M7,
        OP_ROT
    } mul_op_t;

    // Shift-subtract division, elaboration only
    function automatic word_t udiv_f(word_t num, word_t den);
        word_t       q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // ceil(2^QF / 1000); exact floor quotient for numerators below 2^50
    localparam word_t MM_RECIP = udiv_f(QONE + word_t'(MM_PER_M - 1), word_t'(MM_PER_M));

    // (a * b) / 2^s, truncated toward zero, saturated
    function automatic word_t mulq_f(word_t a, word_t b, int s);
        logic         neg;
        word_t        ua;
        word_t        ub;
        logic [127:0] prod;
        logic [127:0] sh;
        word_t        r;
        neg  = a[63] ^ b[63];
        ua   = a[63] ? (~a + 64'd1) : a;
        ub   = b[63] ? (~b + 64'd1) : b;
        prod = {64'd0, ua} * {64'd0, ub};
        sh   = prod >> s;
        r    = (sh[127:63] != '0) ? SAT_POS : sh[63:0];
        return neg ? (~r + 64'd1) : r;
    endfunction

    function automatic word_t invsqrt_f(word_t w);
        word_t y;
        word_t t;
        y = QONE;
        for (int k = 0; k < INV_ITERS; k++) begin
            t = mulq_f(w, mulq_f(y, y, QF), QF);
            y = mulq_f(y, 64'd3 * QONE - t, QF + 1);
        end
        return y;
    endfunction

    // arctan(1/n) by its series
    function automatic word_t atan_recip_f(word_t n);
        word_t p;
        word_t t;
        word_t sum;
        p   = udiv_f(QONE, n);
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != '0) begin
                t   = udiv_f(p, word_t'(2 * k + 1));
                sum = k[0] ? sum - t : sum + t;
                p   = udiv_f(udiv_f(p, n), n);
            end
        end
        return sum;
    endfunction

    function automatic word_t pi_f();
        return 64'd16 * atan_recip_f(64'd5) - 64'd4 * atan_recip_f(64'd239);
    endfunction

    function automatic word_t deg_to_rad_f();
        return udiv_f(pi_f(), 64'd180);
    endfunction

    function automatic word_t atan_entry_f(int i);
        word_t v;
        if (i == 0) begin
            v = pi_f() >> 2;
        end else begin
            v = atan_recip_f(64'd1 << i);
        end
        return v;
    endfunction

    function automatic word_t cordic_gain_f(int steps);
        word_t g;
        g = QONE;
        for (int i = 0; i < steps; i++) begin
            if (2 * i < QF + 1) begin
                g = mulq_f(g, invsqrt_f(QONE + (QONE >> (2 * i))), QF);
            end
        end
        return g;
    endfunction

    // Round to nearest Q30, low 32 bits of the arithmetic shift
    function automatic logic [ROT_W-1:0] q30_f(word_t v);
        word_t s;
        s = v + (64'd1 << (ROT_FRAC - 1));
        return s[ROT_FRAC+ROT_W-1:ROT_FRAC];
    endfunction

    // Clamp to +-2^41 and keep the output width
    function automatic logic [OUT_W-1:0] sat_out_f(word_t v);
        logic signed [63:0] sv;
        sv = signed'(v);
        if (sv > OUT_LIMIT) begin
            sv = OUT_LIMIT;
        end else if (sv < -OUT_LIMIT) begin
            sv = -OUT_LIMIT;
        end
        return sv[OUT_W-1:0];
    endfunction

endpackage

// ===== src/gle_mulq.sv =====
`timescale 1ns / 1ps

// Shared 64x64 fixed-point multiplier: one 32x32 partial product per cycle,
// then shift, saturate and sign fix-up.
module gle_mulq import gle_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output logic     done,
    output word_t    result
);

    logic         busy_reg;
    logic [2:0]   phase_reg;
    logic         neg_reg;
    mul_shift_t   sh_reg;
    word_t        ua_reg;
    word_t        ub_reg;
    logic [127:0] acc_reg;
    word_t        res_reg;
    logic         done_reg;

    logic [31:0]  opa;
    logic [31:0]  opb;
    logic [63:0]  pp;
    logic [127:0] pp_pos;
    logic [127:0] shifted;
    word_t        mag;

    // Partial product select and alignment
    always_comb begin
        opa = phase_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        opb = phase_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp  = 64'(opa) * 64'(opb);
        case (phase_reg)
            3'd0:    pp_pos = {64'd0, pp};
            3'd3:    pp_pos = {pp, 64'd0};
            default: pp_pos = {32'd0, pp, 32'd0};
        endcase
    end

    // Fraction drop and saturation
    always_comb begin
        case (sh_reg)
            SH_Q60:  shifted = acc_reg >> QF;
            SH_Q61:  shifted = acc_reg >> (QF + 1);
            SH_ANG:  shifted = acc_reg >> ANGLE_FRAC_BITS;
            SH_Q30:  shifted = acc_reg >> ROT_FRAC;
            default: shifted = acc_reg >> QF;
        endcase
        mag = (shifted[127:63] != '0) ? SAT_POS : shifted[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg  <= 1'b1;
                phase_reg <= '0;
            end else if (busy_reg) begin
                if (phase_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    phase_reg <= phase_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            neg_reg <= req.a[63] ^ req.b[63];
            ua_reg  <= req.a[63] ? (~req.a + 64'd1) : req.a;
            ub_reg  <= req.b[63] ? (~req.b + 64'd1) : req.b;
            sh_reg  <= req.sh;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (phase_reg == 3'd4) begin
                res_reg <= neg_reg ? (~mag + 64'd1) : mag;
            end else begin
                acc_reg <= acc_reg + pp_pos;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== src/gle_cordic.sv =====
`timescale 1ns / 1ps

// Rotation-mode CORDIC, one micro-rotation per cycle
module gle_cordic import gle_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  word_t z_in,
    input  logic  flip_in,
    output logic  done,
    output word_t sin_out,
    output word_t cos_out
);

    localparam int    IW   = $clog2(CORDIC_STEPS);
    localparam word_t GAIN = cordic_gain_f(CORDIC_STEPS);

    word_t atan_tab [CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
        localparam word_t ATAN_V = atan_entry_f(g);
        assign atan_tab[g] = ATAN_V;
    end

    logic              busy_reg;
    logic              done_reg;
    logic [IW-1:0]     i_reg;
    logic signed [63:0] x_reg;
    logic signed [63:0] y_reg;
    word_t             z_reg;
    logic              flip_reg;
    word_t             sin_reg;
    word_t             cos_reg;

    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] x_next;
    logic signed [63:0] y_next;
    word_t              z_next;

    // One micro-rotation
    always_comb begin
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        if (!z_reg[63]) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - atan_tab[i_reg];
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + atan_tab[i_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end else if (busy_reg) begin
                if (i_reg == IW'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    i_reg <= i_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            x_reg    <= signed'(GAIN);
            y_reg    <= '0;
            z_reg    <= z_in;
            flip_reg <= flip_in;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            if (i_reg == IW'(CORDIC_STEPS - 1)) begin
                sin_reg <= y_next;
                cos_reg <= flip_reg ? -x_next : x_next;
            end
        end
    end

    assign done    = done_reg;
    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// ===== src/gle_div1000.sv =====
`timescale 1ns / 1ps

// Divide by 1000 (millimetres to metres) by multiplying with the rounded-up
// reciprocal and dropping QF fraction bits. The numerator is fed in
// DIV_CHUNKS pieces, most significant first, one narrow product per cycle.
module gle_div1000 import gle_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int PAD_W  = DIV_CHUNK * DIV_CHUNKS;
    localparam int PROD_W = DIV_CHUNK + RECIP_W;
    localparam int ACC_W  = PAD_W + RECIP_W;
    localparam int CW     = $clog2(DIV_CHUNKS);

    logic              busy_reg;
    logic [CW-1:0]     cnt_reg;
    logic [PAD_W-1:0]  num_reg;
    logic [ACC_W-1:0]  acc_reg;

    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  acc_next;

    // Chunk times reciprocal, accumulated Horner style
    always_comb begin
        prod     = PROD_W'(num_reg[PAD_W-1 -: DIV_CHUNK]) *
                   PROD_W'(MM_RECIP[RECIP_W-1:0]);
        acc_next = (acc_reg << DIV_CHUNK) + ACC_W'(prod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == CW'(DIV_CHUNKS - 1)) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= {{(PAD_W - NUM_W){1'b0}}, num};
            acc_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[PAD_W-DIV_CHUNK-1:0], {DIV_CHUNK{1'b0}}};
            acc_reg <= acc_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = NUM_W'(acc_reg >> QF);

endmodule

// ===== src/geodetic_to_local_enu_top.sv =====
`timescale 1ns / 1ps

// Channel   | Ports                                   | Direction
// ----------+-----------------------------------------+-----------
// input     | s_valid/s_ready, s_longitude_deg, ...   | in
// result    | m_valid/m_ready, m_east_m, ..., m_status | out
// config    | cfg_wr_en, cfg_index, cfg_data          | in
//
// One transaction runs two CORDIC passes and a run of multiplies on the shared
// multiplier (38 multiplies for an origin point, 43 otherwise). Mode off skips
// the computation and returns a zero result with m_status set.
// Reset is synchronous, active low.
// s_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so a stalled m_ready holds back only the next one.
module geodetic_to_local_enu_top import gle_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [LON_W-1:0]     s_longitude_deg,
    input  logic [LAT_W-1:0]     s_latitude_deg,
    input  logic [HGT_W-1:0]     s_height_m,
    input  logic                 s_new_origin,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_east_m,
    output logic [OUT_W-1:0]     m_north_m,
    output logic [OUT_W-1:0]     m_up_m,
    output logic                 m_status,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Control state
    seq_state_t       state_reg;
    seq_state_t       state_next;
    mul_op_t          op_reg;
    logic [2:0]       k_reg;
    logic [1:0]       row_reg;
    logic [1:0]       col_reg;
    logic             ang_sel_reg;
    logic             issued_reg;
    logic             origin_valid_reg;
    logic             m_valid_reg;
    logic             mode_reg;
    logic [SEMI_W-1:0] semi_reg;
    logic [ECC_W-1:0] ecc_reg;

    // Datapath
    logic [LON_W-1:0] lon_reg;
    logic [LAT_W-1:0] lat_reg;
    logic [HGT_W-1:0] h_reg;
    logic             org_reg;
    logic signed [RED_W-1:0] r_reg;
    logic             flip_reg;
    word_t            z_reg;
    word_t            sl_reg;
    word_t            cl_reg;
    word_t            sp_reg;
    word_t            cp_reg;
    word_t            w_reg;
    word_t            y_reg;
    word_t            t_reg;
    word_t            n_reg;
    word_t            pc_reg;
    word_t            p0_reg;
    word_t            p1_reg;
    word_t            p2_reg;
    word_t            acc_reg;
    word_t            d_reg [3];
    logic [ORG_W-1:0] org_ecef_reg [3];
    logic [ROT_W-1:0] rot_reg [3][3];
    logic [OUT_W-1:0] res_east_reg;
    logic [OUT_W-1:0] res_north_reg;
    logic [OUT_W-1:0] res_up_reg;
    logic             res_status_reg;
    logic [OUT_W-1:0] m_east_reg;
    logic [OUT_W-1:0] m_north_reg;
    logic [OUT_W-1:0] m_up_reg;
    logic             m_status_reg;

    // Unit hookup
    mul_req_t         mul_req;
    logic             mul_done;
    word_t            mul_res;
    logic             cord_start;
    logic             cord_done;
    word_t            cord_sin;
    word_t            cord_cos;
    logic             div_start;
    logic             div_busy;
    logic [NUM_W-1:0] div_quo;

    logic             accept;
    logic             out_load;
    logic             is_origin;
    word_t            e2;
    word_t            h64;
    word_t            a_len;
    word_t            rot_sel;
    word_t            d_sel;
    word_t            row_sum;
    logic signed [RED_W-1:0] ang;
    logic signed [RED_W-1:0] r1;
    logic signed [RED_W-1:0] r2;
    logic signed [RED_W-1:0] r3;
    logic             flip;

    localparam word_t D2R = deg_to_rad_f();

    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign is_origin = org_reg || !origin_valid_reg;
    assign e2        = {{(64 - ECC_W - ECC_SHIFT){1'b0}}, ecc_reg, {ECC_SHIFT{1'b0}}};
    assign h64       = {{(64 - HGT_W){h_reg[HGT_W-1]}}, h_reg};
    assign a_len     = {{(64 - NUM_W){1'b0}}, div_quo};
    assign rot_sel   = {{(64 - ROT_W){rot_reg[row_reg][col_reg][ROT_W-1]}},
                        rot_reg[row_reg][col_reg]};
    assign d_sel     = d_reg[col_reg];
    assign row_sum   = acc_reg + mul_res;

    // Angle range reduction to [-90, 90] degrees; the input magnitude is
    // always below one turn, so the remainder step is the identity
    always_comb begin
        if (ang_sel_reg) begin
            ang = {{(RED_W - LAT_W){lat_reg[LAT_W-1]}}, lat_reg};
        end else begin
            ang = {{(RED_W - LON_W){lon_reg[LON_W-1]}}, lon_reg};
        end
        r1   = (ang < 0) ? ang + TURN : ang;
        r2   = (r1 >= HALF) ? r1 - TURN : r1;
        flip = 1'b0;
        r3   = r2;
        if (r2 > QUARTER) begin
            r3   = HALF - r2;
            flip = 1'b1;
        end else if (r2 < -QUARTER) begin
            r3   = -HALF - r2;
            flip = 1'b1;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = mode_reg ? S_REDUCE : S_DONE;
                end
            end
            S_REDUCE: state_next = S_ZMUL;
            S_ZMUL: begin
                if (mul_done) begin
                    state_next = S_CORDIC;
                end
            end
            S_CORDIC: begin
                if (cord_done) begin
                    state_next = ang_sel_reg ? S_MUL : S_REDUCE;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    if (op_reg == OP_P2 && !is_origin) begin
                        state_next = S_DIFF;
                    end else if (op_reg == OP_M7) begin
                        state_next = S_DONE;
                    end else if (op_reg == OP_ROT && row_reg == 2'd2 && col_reg == 2'd2) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIFF: state_next = S_MUL;
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, unit starts and multiplier operand select
    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        div_start     = accept;
        cord_start    = (state_reg == S_CORDIC) && !issued_reg;
        mul_req.start = !issued_reg &&
                        ((state_reg == S_ZMUL) ||
                         (state_reg == S_MUL && !(op_reg == OP_N && div_busy)));
        mul_req.sh    = SH_Q60;
        mul_req.a     = sp_reg;
        mul_req.b     = sp_reg;
        if (state_reg == S_ZMUL) begin
            mul_req.sh = SH_ANG;
            mul_req.a  = {{(64 - RED_W){r_reg[RED_W-1]}}, r_reg};
            mul_req.b  = D2R;
        end else begin
            case (op_reg)
                OP_SPSP: begin
                    mul_req.a = sp_reg;
                    mul_req.b = sp_reg;
                end
                OP_E2W: begin
                    mul_req.a = e2;
                    mul_req.b = t_reg;
                end
                OP_YY: begin
                    mul_req.a = y_reg;
                    mul_req.b = y_reg;
                end
                OP_WT: begin
                    mul_req.a = w_reg;
                    mul_req.b = t_reg;
                end
                OP_Y: begin
                    mul_req.sh = SH_Q61;
                    mul_req.a  = y_reg;
                    mul_req.b  = 64'd3 * QONE - t_reg;
                end
                OP_N: begin
                    mul_req.a = a_len;
                    mul_req.b = y_reg;
                end
                OP_PC: begin
                    mul_req.a = n_reg + h64;
                    mul_req.b = cp_reg;
                end
                OP_P0: begin
                    mul_req.a = pc_reg;
                    mul_req.b = cl_reg;
                end
                OP_P1: begin
                    mul_req.a = pc_reg;
                    mul_req.b = sl_reg;
                end
                OP_NE: begin
                    mul_req.a = n_reg;
                    mul_req.b = QONE - e2;
                end
                OP_P2: begin
                    mul_req.a = t_reg + h64;
                    mul_req.b = sp_reg;
                end
                OP_M3: begin
                    mul_req.a = sp_reg;
                    mul_req.b = cl_reg;
                end
                OP_M4: begin
                    mul_req.a = sp_reg;
                    mul_req.b = sl_reg;
                end
                OP_M6: begin
                    mul_req.a = cp_reg;
                    mul_req.b = cl_reg;
                end
                OP_M7: begin
                    mul_req.a = cp_reg;
                    mul_req.b = sl_reg;
                end
                OP_ROT: begin
                    mul_req.sh = SH_Q30;
                    mul_req.a  = rot_sel;
                    mul_req.b  = d_sel;
                end
                default: begin
                    mul_req.a = sp_reg;
                    mul_req.b = sp_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_SPSP;
            k_reg            <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            ang_sel_reg      <= 1'b0;
            issued_reg       <= 1'b0;
            origin_valid_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
            mode_reg         <= 1'b0;
            semi_reg         <= SEMI_W'(64'd6378137000);
            ecc_reg          <= ECC_W'(64'd1884300451891);
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_data[0];
                    CFG_SEMI: semi_reg <= cfg_data[SEMI_W-1:0];
                    CFG_ECC:  ecc_reg  <= cfg_data[ECC_W-1:0];
                    default:  ;
                endcase
            end

            if (mul_req.start || cord_start) begin
                issued_reg <= 1'b1;
            end else if (mul_done || cord_done) begin
                issued_reg <= 1'b0;
            end

            if (accept) begin
                ang_sel_reg <= 1'b0;
            end

            if (state_reg == S_CORDIC && cord_done) begin
                ang_sel_reg <= 1'b1;
                op_reg      <= OP_SPSP;
            end

            if (state_reg == S_DIFF) begin
                op_reg  <= OP_ROT;
                row_reg <= '0;
                col_reg <= '0;
            end

            // Microprogram sequencing
            if (state_reg == S_MUL && mul_done) begin
                case (op_reg)
                    OP_SPSP: op_reg <= OP_E2W;
                    OP_E2W: begin
                        op_reg <= OP_YY;
                        k_reg  <= '0;
                    end
                    OP_YY: op_reg <= OP_WT;
                    OP_WT: op_reg <= OP_Y;
                    OP_Y: begin
                        if (k_reg == 3'(INV_ITERS - 1)) begin
                            op_reg <= OP_N;
                        end else begin
                            k_reg  <= k_reg + 3'd1;
                            op_reg <= OP_YY;
                        end
                    end
                    OP_N:  op_reg <= OP_PC;
                    OP_PC: op_reg <= OP_P0;
                    OP_P0: op_reg <= OP_P1;
                    OP_P1: op_reg <= OP_NE;
                    OP_NE: op_reg <= OP_P2;
                    OP_P2: begin
                        if (is_origin) begin
                            op_reg <= OP_M3;
                        end
                    end
                    OP_M3: op_reg <= OP_M4;
                    OP_M4: op_reg <= OP_M6;
                    OP_M6: op_reg <= OP_M7;
                    OP_M7: origin_valid_reg <= 1'b1;
                    OP_ROT: begin
                        if (col_reg == 2'd2) begin
                            col_reg <= '0;
                            row_reg <= row_reg + 2'd1;
                        end else begin
                            col_reg <= col_reg + 2'd1;
                        end
                    end
                    default: op_reg <= OP_SPSP;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            lon_reg <= s_longitude_deg;
            lat_reg <= s_latitude_deg;
            h_reg   <= s_height_m;
            org_reg <= s_new_origin;
            if (!mode_reg) begin
                res_east_reg   <= '0;
                res_north_reg  <= '0;
                res_up_reg     <= '0;
                res_status_reg <= 1'b1;
            end
        end

        if (state_reg == S_REDUCE) begin
            r_reg    <= r3;
            flip_reg <= flip;
        end

        if (state_reg == S_ZMUL && mul_done) begin
            z_reg <= mul_res;
        end

        if (state_reg == S_CORDIC && cord_done) begin
            if (ang_sel_reg) begin
                sp_reg <= cord_sin;
                cp_reg <= cord_cos;
            end else begin
                sl_reg <= cord_sin;
                cl_reg <= cord_cos;
            end
        end

        if (state_reg == S_DIFF) begin
            d_reg[0] <= p0_reg - {{(64 - ORG_W){org_ecef_reg[0][ORG_W-1]}}, org_ecef_reg[0]};
            d_reg[1] <= p1_reg - {{(64 - ORG_W){org_ecef_reg[1][ORG_W-1]}}, org_ecef_reg[1]};
            d_reg[2] <= p2_reg - {{(64 - ORG_W){org_ecef_reg[2][ORG_W-1]}}, org_ecef_reg[2]};
            acc_reg  <= '0;
        end

        // Result write-back
        if (state_reg == S_MUL && mul_done) begin
            case (op_reg)
                OP_SPSP: t_reg <= mul_res;
                OP_E2W: begin
                    w_reg <= QONE - mul_res;
                    y_reg <= QONE;
                end
                OP_YY: t_reg <= mul_res;
                OP_WT: t_reg <= mul_res;
                OP_Y:  y_reg <= mul_res;
                OP_N:  n_reg <= mul_res;
                OP_PC: pc_reg <= mul_res;
                OP_P0: p0_reg <= mul_res;
                OP_P1: p1_reg <= mul_res;
                OP_NE: t_reg <= mul_res;
                OP_P2: begin
                    p2_reg <= mul_res;
                    if (is_origin) begin
                        org_ecef_reg[0] <= p0_reg[ORG_W-1:0];
                        org_ecef_reg[1] <= p1_reg[ORG_W-1:0];
                        org_ecef_reg[2] <= mul_res[ORG_W-1:0];
                        res_east_reg    <= '0;
                        res_north_reg   <= '0;
                        res_up_reg      <= '0;
                        res_status_reg  <= 1'b0;
                    end
                end
                OP_M3: rot_reg[1][0] <= q30_f(-mul_res);
                OP_M4: rot_reg[1][1] <= q30_f(-mul_res);
                OP_M6: rot_reg[2][0] <= q30_f(mul_res);
                OP_M7: begin
                    rot_reg[2][1] <= q30_f(mul_res);
                    rot_reg[0][0] <= q30_f(-sl_reg);
                    rot_reg[0][1] <= q30_f(cl_reg);
                    rot_reg[0][2] <= '0;
                    rot_reg[1][2] <= q30_f(cp_reg);
                    rot_reg[2][2] <= q30_f(sp_reg);
                end
                OP_ROT: begin
                    if (col_reg == 2'd2) begin
                        acc_reg <= '0;
                        case (row_reg)
                            2'd0:    res_east_reg  <= sat_out_f(row_sum);
                            2'd1:    res_north_reg <= sat_out_f(row_sum);
                            default: res_up_reg    <= sat_out_f(row_sum);
                        endcase
                        res_status_reg <= 1'b0;
                    end else begin
                        acc_reg <= row_sum;
                    end
                end
                default: t_reg <= mul_res;
            endcase
        end

        if (out_load) begin
            m_east_reg   <= res_east_reg;
            m_north_reg  <= res_north_reg;
            m_up_reg     <= res_up_reg;
            m_status_reg <= res_status_reg;
        end
    end

    gle_mulq u_mulq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .result  (mul_res)
    );

    gle_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .z_in    (z_reg),
        .flip_in (flip_reg),
        .done    (cord_done),
        .sin_out (cord_sin),
        .cos_out (cord_cos)
    );

    gle_div1000 u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({semi_reg, {LENGTH_FRAC_BITS{1'b0}}}),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    assign m_valid   = m_valid_reg;
    assign m_east_m  = m_east_reg;
    assign m_north_m = m_north_reg;
    assign m_up_m    = m_up_reg;
    assign m_status  = m_status_reg;

endmodule
